// ===== rtl/tovn_pkg.sv =====
package tovn_pkg;

  // Field and register widths.
  localparam int SEED_W     = 32;
  localparam int INV_CELL_W = 17;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int GRAY_W     = 8;
  localparam int VAL_W      = 16;

  localparam logic [INV_CELL_W-1:0] INV_CELL_RST = 17'd4096;

  // Hash multipliers.
  localparam logic [31:0] HASH_KX = 32'd374761393;
  localparam logic [31:0] HASH_KY = 32'd668265263;
  localparam logic [31:0] HASH_KS = 32'd2246822519;
  localparam logic [31:0] HASH_KM = 32'd1274126177;

  // Smoothstep constant 3.0 in Q2.16.
  localparam logic [17:0] SMOOTH_K3 = 18'd196608;

  // Octave mix weight 0.7 in Q0.16; the second octave gets the rest of one.
  localparam logic [15:0] MIX_HI = 16'd45875;

  localparam logic [GRAY_W-1:0] GRAY_BASE = 8'd180;
  localparam logic [5:0]        GRAY_SPAN = 6'd60;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SEED     = 1'b0,
    CFG_INV_CELL = 1'b1
  } cfg_reg_t;

endpackage

// ===== rtl/tovn_pix_if.sv =====
interface tovn_pix_if #(
  parameter int COORD_BITS = 12
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;

  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

// ===== rtl/tovn_gray_if.sv =====
interface tovn_gray_if;
  logic       valid;
  logic       ready;
  logic [7:0] gray;

  modport source (output valid, output gray, input ready);
  modport sink   (input valid, input gray, output ready);
endinterface

// ===== rtl/two_octave_value_noise_pixel.sv =====
// Two-octave 2D value noise, one gray level per pixel coordinate.
//
// The input channel in_pix carries one item per pixel (pixel_x, pixel_y); the
// result channel out_gray carries one gray level (180..239) per input item,
// in the same order. Both channels use a valid/ready handshake, and an item
// moves at a rising edge where both are high.
// Two registers are written through the cfg_ port: index 0 is the hash seed
// (the second octave hashes with seed plus one), index 1 is the reciprocal
// cell size with FRAC_BITS fraction bits. Write them only while no item is
// in flight.
// The datapath is a nine-stage pipeline whose last stage is the out_gray
// output register. One item is taken every clock as long as the receiver
// keeps up, so the sustained rate is one item per cycle, set by the
// per-stage multipliers that all run every cycle.
// When the receiver stalls, the output stage holds its item and each earlier
// stage keeps accepting until it meets a full stage ahead of it, so empty
// slots fill up before in_pix.ready drops.
// A synchronous reset (rst_n low) empties the pipeline, sets the seed to zero
// and the reciprocal cell size to 4096.
module two_octave_value_noise_pixel
  import tovn_pkg::*;
#(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  tovn_pix_if.sink              in_pix,
  tovn_gray_if.source           out_gray,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Lattice position widths. PW holds pixel times reciprocal exactly. The
  // second octave is at most 3.3 times larger, so two more integer bits cover
  // it; LW also keeps at least one integer bit.
  localparam int PW = COORD_BITS + INV_CELL_W;
  localparam int KW = FRAC_BITS + 2;
  localparam int LW = (PW + 2 > FRAC_BITS) ? PW + 2 : FRAC_BITS + 1;
  localparam logic [KW-1:0] K33 = KW'(((64'd33 << FRAC_BITS) + 64'd5) / 64'd10);
  localparam int NS = 9;

  // Fraction of a lattice position brought to Q0.16 by truncation or
  // zero-fill.
  function automatic logic [VAL_W-1:0] frac16(input logic [LW-1:0] pos);
    logic [FRAC_BITS+15:0] tmp;
    tmp = {pos[FRAC_BITS-1:0], 16'd0};
    return tmp[FRAC_BITS+15 -: 16];
  endfunction

  // a*(1-w) + b*w rewritten as a + (b-a)*w, with an arithmetic shift so the
  // floor matches the unsigned form.
  function automatic logic [VAL_W-1:0] lerp16(input logic [VAL_W-1:0] a,
                                              input logic [VAL_W-1:0] b,
                                              input logic [VAL_W-1:0] w);
    logic signed [16:0] d;
    logic signed [34:0] p;
    logic signed [34:0] s;
    d = $signed({1'b0, b}) - $signed({1'b0, a});
    p = d * $signed({1'b0, w});
    s = $signed({19'd0, a}) + (p >>> 16);
    return s[VAL_W-1:0];
  endfunction

  function automatic logic [VAL_W-1:0] smooth16(input logic [VAL_W-1:0] t,
                                                input logic [VAL_W-1:0] t2);
    logic [33:0] p;
    p = 34'(t2) * 34'(SMOOTH_K3 - {1'b0, t, 1'b0});
    return (|p[33:32]) ? 16'hFFFF : p[31:16];
  endfunction

  // Configuration registers.
  logic [SEED_W-1:0]     seed_r;
  logic [INV_CELL_W-1:0] inv_cell_r;
  logic [31:0]           seed_ks_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r     <= '0;
      inv_cell_r <= INV_CELL_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_SEED:     seed_r     <= cfg_wdata[SEED_W-1:0];
        CFG_INV_CELL: inv_cell_r <= cfg_wdata[INV_CELL_W-1:0];
        default:      ;
      endcase
    end
  end

  // Seed term of the hash; seed plus one adds one more HASH_KS.
  always_ff @(posedge clk) begin
    seed_ks_r <= seed_r * HASH_KS;
  end

  // Pipeline control: a stage loads when it is empty or its item moves on.
  logic [NS-1:0] v_r;
  logic [NS:0]   stage_rdy;

  always_comb begin
    stage_rdy[NS] = out_gray.ready;
    for (int i = NS - 1; i >= 0; i--) begin
      stage_rdy[i] = !v_r[i] || stage_rdy[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (stage_rdy[0]) begin
        v_r[0] <= in_pix.valid;
      end
      for (int i = 1; i < NS; i++) begin
        if (stage_rdy[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  assign in_pix.ready   = stage_rdy[0];
  assign out_gray.valid = v_r[NS-1];

  // Stage 0: first-octave lattice position.
  logic [PW-1:0] px_r, py_r;

  always_ff @(posedge clk) begin
    if (stage_rdy[0]) begin
      px_r <= PW'(in_pix.pixel_x) * PW'(inv_cell_r);
      py_r <= PW'(in_pix.pixel_y) * PW'(inv_cell_r);
    end
  end

  // Stage 1: second-octave position at 3.3 times the frequency.
  // Index [octave][0 = x, 1 = y].
  logic [LW-1:0]       pos_r [2][2];
  logic [PW+KW-1:0]    qx_prod, qy_prod;

  always_comb begin
    qx_prod = (PW+KW)'(px_r) * (PW+KW)'(K33);
    qy_prod = (PW+KW)'(py_r) * (PW+KW)'(K33);
  end

  always_ff @(posedge clk) begin
    if (stage_rdy[1]) begin
      pos_r[0][0] <= LW'(px_r);
      pos_r[0][1] <= LW'(py_r);
      pos_r[1][0] <= LW'(qx_prod >> FRAC_BITS);
      pos_r[1][1] <= LW'(qy_prod >> FRAC_BITS);
    end
  end

  // Stage 2: cell index products and the squared fraction.
  logic [31:0]      ax_r [2];
  logic [31:0]      ay_r [2];
  logic [VAL_W-1:0] t_r  [2][2];
  logic [VAL_W-1:0] t2_r [2][2];

  always_ff @(posedge clk) begin
    if (stage_rdy[2]) begin
      for (int o = 0; o < 2; o++) begin
        ax_r[o] <= 32'(pos_r[o][0][LW-1:FRAC_BITS]) * HASH_KX;
        ay_r[o] <= 32'(pos_r[o][1][LW-1:FRAC_BITS]) * HASH_KY;
        for (int d = 0; d < 2; d++) begin
          t_r[o][d]  <= frac16(pos_r[o][d]);
          t2_r[o][d] <= 16'((32'(frac16(pos_r[o][d])) * 32'(frac16(pos_r[o][d]))) >> 16);
        end
      end
    end
  end

  // Stage 3: smoothstep weights and the first mixing round of the four
  // corner hashes. Corner order: (x0,y0), (x1,y0), (x0,y1), (x1,y1).
  logic [VAL_W-1:0] w3_r [2][2];
  logic [31:0]      hm_r [2][4];
  logic [31:0]      h_base [2];
  logic [31:0]      h_c    [2][4];

  always_comb begin
    for (int o = 0; o < 2; o++) begin
      h_base[o] = ax_r[o] + ay_r[o] + seed_ks_r + ((o == 1) ? HASH_KS : 32'd0);
      h_c[o][0] = h_base[o];
      h_c[o][1] = h_base[o] + HASH_KX;
      h_c[o][2] = h_base[o] + HASH_KY;
      h_c[o][3] = h_base[o] + HASH_KX + HASH_KY;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_rdy[3]) begin
      for (int o = 0; o < 2; o++) begin
        for (int d = 0; d < 2; d++) begin
          w3_r[o][d] <= smooth16(t_r[o][d], t2_r[o][d]);
        end
        for (int c = 0; c < 4; c++) begin
          hm_r[o][c] <= h_c[o][c] ^ (h_c[o][c] >> 13);
        end
      end
    end
  end

  // Stage 4: final hash multiply.
  logic [VAL_W-1:0] w4_r [2][2];
  logic [31:0]      hk_r [2][4];

  always_ff @(posedge clk) begin
    if (stage_rdy[4]) begin
      for (int o = 0; o < 2; o++) begin
        w4_r[o] <= w3_r[o];
        for (int c = 0; c < 4; c++) begin
          hk_r[o][c] <= hm_r[o][c] * HASH_KM;
        end
      end
    end
  end

  // Stage 5: corner values and the horizontal blends.
  logic [VAL_W-1:0] corner [2][4];
  logic [VAL_W-1:0] ra_r [2];
  logic [VAL_W-1:0] rb_r [2];
  logic [VAL_W-1:0] wy_r [2];

  always_comb begin
    for (int o = 0; o < 2; o++) begin
      for (int c = 0; c < 4; c++) begin
        corner[o][c] = hk_r[o][c][15:0] ^ hk_r[o][c][31:16];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stage_rdy[5]) begin
      for (int o = 0; o < 2; o++) begin
        ra_r[o] <= lerp16(corner[o][0], corner[o][1], w4_r[o][0]);
        rb_r[o] <= lerp16(corner[o][2], corner[o][3], w4_r[o][0]);
        wy_r[o] <= w4_r[o][1];
      end
    end
  end

  // Stage 6: vertical blend gives each octave's noise value.
  logic [VAL_W-1:0] n_r [2];

  always_ff @(posedge clk) begin
    if (stage_rdy[6]) begin
      for (int o = 0; o < 2; o++) begin
        n_r[o] <= lerp16(ra_r[o], rb_r[o], wy_r[o]);
      end
    end
  end

  // Stage 7: octave mix, n2 + (n1 - n2) * 0.7.
  logic [VAL_W-1:0]   nmix_r;
  logic signed [16:0] mix_d;
  logic signed [33:0] mix_p;
  logic signed [33:0] mix_s;

  always_comb begin
    mix_d = $signed({1'b0, n_r[0]}) - $signed({1'b0, n_r[1]});
    mix_p = mix_d * $signed({1'b0, MIX_HI});
    mix_s = $signed({18'd0, n_r[1]}) + (mix_p >>> 16);
  end

  always_ff @(posedge clk) begin
    if (stage_rdy[7]) begin
      nmix_r <= mix_s[VAL_W-1:0];
    end
  end

  // Stage 8: map to the gray range; this is the output register.
  logic [GRAY_W-1:0] gray_r;
  logic [21:0]       gray_p;

  assign gray_p = 22'(nmix_r) * 22'(GRAY_SPAN);

  always_ff @(posedge clk) begin
    if (stage_rdy[8]) begin
      gray_r <= GRAY_BASE + 8'(gray_p[21:16]);
    end
  end

  assign out_gray.gray = gray_r;

  // The gray level never leaves the mapped range.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_gray.valid |-> (out_gray.gray >= 8'd180) && (out_gray.gray <= 8'd239))
    else $error("gray level out of range");

  // Input back-pressure only comes from a stalled, full output stage.
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_pix.ready |-> (out_gray.valid && !out_gray.ready))
    else $error("input stalled without an output stall");

  // An item that moves into the output stage shows up there next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[NS-2] && stage_rdy[NS-1]) |=> v_r[NS-1])
    else $error("item lost before the output stage");

endmodule
